/* rtl/cdt_pkg.sv */
// cdt_pkg: types and constants for the contact duration tracker
// no dependencies
package cdt_pkg;
    localparam int TABLE_ENTRIES = 4096;
    localparam int ID_BITS = 24;
    localparam int TIME_BITS = 32;
    localparam int KEY_BITS = 2 * ID_BITS + 1;
    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS = IDX_BITS + 1;
    localparam int STEP_BITS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam logic ACT_CONTACT = 1'b0;
    localparam logic ACT_FRAME = 1'b1;
    localparam logic [0:0] REG_TIME_STEP = 1'b0;
    localparam logic [STEP_BITS-1:0] TIME_STEP_RESET = 16'd10;

    typedef struct packed {
        logic action;
        logic contact_kind;
        logic [ID_BITS-1:0] id_first;
        logic [ID_BITS-1:0] id_second;
    } in_t;

    typedef struct packed {
        logic out_kind;
        logic [ID_BITS-1:0] out_first;
        logic [ID_BITS-1:0] out_second;
        logic [TIME_BITS-1:0] contact_time;
        logic is_new;
        logic table_full;
    } out_t;

    typedef struct packed {
        logic is_frame;
        logic [KEY_BITS-1:0] key;
    } op_t;
endpackage

/* rtl/cdt_front.sv */
// cdt_front: accepts requests and classifies them into queue operations
// depends on cdt_pkg
module cdt_front import cdt_pkg::*;
(
    input  logic start,
    input  in_t  request,
    input  logic queue_full,
    output logic busy,
    output logic push,
    output op_t  op
);
    assign busy = queue_full;
    assign push = start && !queue_full;
    always_comb
    begin
        op.is_frame = (request.action == ACT_FRAME);
        op.key = {request.contact_kind, request.id_first, request.id_second};
    end
endmodule

/* rtl/cdt_queue.sv */
// cdt_queue: short fifo of operations between front and back
// depends on cdt_pkg
module cdt_queue import cdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic empty,
    output logic full,
    output op_t  head
);
    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    op_t slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [PTR_BITS:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign head = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_op;
    end
endmodule

/* rtl/cdt_back.sv */
// cdt_back: table search and update engine with banked key/time memory
// depends on cdt_pkg
module cdt_back import cdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  op_t                  head,
    input  logic [STEP_BITS-1:0] time_step,
    output logic                 pop,
    output logic                 done,
    output out_t                 result
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PRD = 3'd1, S_PCMP = 3'd2,
                           S_CRD = 3'd3, S_CCMP = 3'd4, S_OUT = 3'd5;
    localparam int ENT_BITS = KEY_BITS + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [ENT_BITS-1:0] mem [2*TABLE_ENTRIES];
    logic [ENT_BITS-1:0] rdata_reg;
    logic [2:0] state_reg, state_next;
    logic bank_reg;
    logic [CNT_BITS-1:0] prev_cnt_reg, cur_cnt_reg, idx_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic new_reg, full_reg;
    logic rd_en, wr_en;
    logic [IDX_BITS:0] rd_addr, wr_addr;
    logic [TIME_BITS:0] sum;
    logic [TIME_BITS-1:0] sat_time, step_time;
    logic hit;

    assign step_time = TIME_BITS'(time_step);
    assign sum = {1'b0, rdata_reg[TIME_BITS-1:0]} + {1'b0, step_time};
    assign sat_time = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    assign hit = (rdata_reg[ENT_BITS-1:TIME_BITS] == key_reg);

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        rd_addr = {~bank_reg, idx_reg[IDX_BITS-1:0]};
        wr_addr = {bank_reg, idx_reg[IDX_BITS-1:0]};
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    state_next = head.is_frame ? S_IDLE : S_PRD;
                end
            end
            S_PRD:
            begin
                if (idx_reg == prev_cnt_reg)
                    state_next = S_CRD;
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
                state_next = hit ? S_CRD : S_PRD;
            S_CRD:
            begin
                rd_addr = {bank_reg, idx_reg[IDX_BITS-1:0]};
                if (idx_reg == cur_cnt_reg)
                begin
                    wr_en = (cur_cnt_reg != CNT_BITS'(TABLE_ENTRIES));
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_CCMP;
                end
            end
            S_CCMP:
            begin
                wr_en = hit;
                state_next = hit ? S_OUT : S_CRD;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= {key_reg, time_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg <= 1'b0;
            prev_cnt_reg <= '0;
            cur_cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= (state_reg == S_OUT);
            if (state_reg == S_IDLE && !empty && head.is_frame)
            begin
                bank_reg <= ~bank_reg;
                prev_cnt_reg <= cur_cnt_reg;
                cur_cnt_reg <= '0;
            end
            if (state_reg == S_CRD && idx_reg == cur_cnt_reg &&
                cur_cnt_reg != CNT_BITS'(TABLE_ENTRIES))
                cur_cnt_reg <= cur_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                key_reg <= head.key;
                idx_reg <= '0;
                time_reg <= step_time;
                new_reg <= 1'b1;
                full_reg <= 1'b0;
            end
            S_PRD:
                if (idx_reg == prev_cnt_reg)
                    idx_reg <= '0;
            S_PCMP:
                if (hit)
                begin
                    time_reg <= sat_time;
                    new_reg <= 1'b0;
                    idx_reg <= '0;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            S_CRD:
                if (idx_reg == cur_cnt_reg)
                    full_reg <= (cur_cnt_reg == CNT_BITS'(TABLE_ENTRIES));
            S_CCMP:
                if (!hit)
                    idx_reg <= idx_reg + 1'b1;
            S_OUT:
            begin
                result.out_kind <= key_reg[KEY_BITS-1];
                result.out_first <= key_reg[2*ID_BITS-1:ID_BITS];
                result.out_second <= key_reg[ID_BITS-1:0];
                result.contact_time <= time_reg;
                result.is_new <= new_reg;
                result.table_full <= full_reg;
            end
            default:
                idx_reg <= idx_reg;
        endcase
    end

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_OUT)
        else $error("result strobe without finished search");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_cnt_reg <= CNT_BITS'(TABLE_ENTRIES) && prev_cnt_reg <= CNT_BITS'(TABLE_ENTRIES))
        else $error("table count beyond capacity");
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !empty && head.is_frame) |=> cur_cnt_reg == '0)
        else $error("frame end did not clear current table");
endmodule

/* rtl/contact_duration_tracker_core.sv */
// contact_duration_tracker_core: top level with apb register and front/queue/back
// depends on cdt_pkg, cdt_front, cdt_queue, cdt_back
// A contact request scans the previous table and then the current table; each table is
// scanned one entry at a time through the single read port of the table memory, and a
// key that is found ends its scan early. A frame-end request swaps banks, moves the
// current entry count to the previous table, clears the current one and gives no result.
// Two requests can wait in the queue, busy is high while it is full, and each
// result is shown for one cycle on done, since the receiver cannot stall.
module contact_duration_tracker_core import cdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_t         request,
    output logic        busy,
    output logic        done,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [STEP_BITS-1:0] step_reg;
    logic push, pop, q_empty, q_full;
    op_t push_op, head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIME_STEP) ? {16'd0, step_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= TIME_STEP_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_TIME_STEP)
            step_reg <= pwdata[STEP_BITS-1:0];
    end

    cdt_front u_front (
        .start(start), .request(request), .queue_full(q_full),
        .busy(busy), .push(push), .op(push_op)
    );

    cdt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op), .pop(pop),
        .empty(q_empty), .full(q_full), .head(head)
    );

    cdt_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(q_empty), .head(head),
        .time_step(step_reg), .pop(pop), .done(done), .result(result)
    );
endmodule
